@@ rtl/rmb_pkg.sv @@
// Shared types, codes and constants for the region-mapped memory bus.
package rmb_pkg;

  localparam int MAX_REGIONS      = 4;
  localparam int RIW              = 2;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 64;
  localparam int LANES            = 8;
  localparam int DEF_NUM_REGIONS  = 4;
  localparam int DEF_REGION_BYTES = 65536;

  localparam logic [CFG_IDX_W-1:0] CFG_REGION_ENABLE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_ONLY     = 3'd5;

  typedef enum logic [1:0] {
    CMD_READ    = 2'd0,
    CMD_WRITE   = 2'd1,
    CMD_PRELOAD = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    SIZE_BYTE  = 2'd0,
    SIZE_WORD  = 2'd1,
    SIZE_DWORD = 2'd2,
    SIZE_QWORD = 2'd3
  } size_e;

  typedef enum logic [1:0] {
    FAULT_NONE = 2'd0,
    FAULT_ADDR = 2'd1,
    FAULT_RO   = 2'd2
  } fault_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_RESP
  } state_e;

  // Result of decoding one address against the region table
  typedef struct packed {
    logic           hit;
    logic           ro;
    logic [RIW-1:0] idx;
    logic [31:0]    base;
  } match_t;

endpackage

@@ rtl/rmb_ram.sv @@
// Generic single-port synchronous RAM with registered read data.
module rmb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/rmb_regions.sv @@
// Region configuration registers and start-address decoder.
module rmb_regions import rmb_pkg::*; #(
  parameter int NUM_REGIONS = DEF_NUM_REGIONS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic [31:0]           address_i,
  output match_t                match_o
);

  logic [63:0]            bounds_q [MAX_REGIONS];
  logic [MAX_REGIONS-1:0] enable_q;
  logic [MAX_REGIONS-1:0] ro_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_REGIONS; i++) begin
        bounds_q[i] <= '0;
      end
      enable_q <= '0;
      ro_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_REGION_ENABLE: enable_q <= cfg_wdata_i[MAX_REGIONS-1:0];
        CFG_READ_ONLY:     ro_q     <= cfg_wdata_i[MAX_REGIONS-1:0];
        default: begin
          if (cfg_idx_i < CFG_IDX_W'(MAX_REGIONS)) begin
            bounds_q[cfg_idx_i[RIW-1:0]] <= cfg_wdata_i;
          end
        end
      endcase
    end
  end

  // Walk from the top so the lowest enabled match wins
  always_comb begin
    match_o = '0;
    for (int i = MAX_REGIONS - 1; i >= 0; i--) begin
      if (i < NUM_REGIONS && enable_q[i] &&
          address_i >= bounds_q[i][31:0] && address_i <= bounds_q[i][63:32]) begin
        match_o.hit  = 1'b1;
        match_o.ro   = ro_q[i];
        match_o.idx  = RIW'(i);
        match_o.base = bounds_q[i][31:0];
      end
    end
  end

endmodule

@@ rtl/region_mapped_memory_bus.sv @@
// An accepted transaction passes through ST_ACCESS and then ST_RESP, where it strobes done_o.
// busy is high only in the store access state, so no new transaction is accepted there;
// the next start can be taken while done_o is high.
// The store is eight byte-lane RAMs with registered reads; an unaligned access
// addresses each lane at its own row, so no access is split into several RAM accesses.
// Reset clears the region registers and control state; store contents stay undefined.
module region_mapped_memory_bus import rmb_pkg::*; #(
  parameter int NUM_REGIONS  = DEF_NUM_REGIONS,
  parameter int REGION_BYTES = DEF_REGION_BYTES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            command_i,
  input  logic [1:0]            access_size_i,
  input  logic [31:0]           address_i,
  input  logic [63:0]           write_data_i,
  output logic                  done_o,
  output logic signed [63:0]    read_data_o,
  output logic [1:0]            fault_code_o,
  output logic [31:0]           fault_address_o
);

  // REGION_BYTES is a power of two, at least two rows of lanes
  localparam int OFFW       = $clog2(REGION_BYTES);
  localparam int LW         = $clog2(LANES);
  localparam int ROWW       = OFFW - LW;
  localparam int ROWS       = REGION_BYTES / LANES;
  localparam int BANK_DEPTH = NUM_REGIONS * ROWS;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);

  state_e state_q, state_d;
  logic   accept;
  logic   in_access;

  cmd_e        cmd_q;
  size_e       size_q;
  logic [31:0] addr_q;
  logic [63:0] wdata_q;
  match_t      match_q;
  match_t      match;
  logic [LW-1:0] lane0_q;

  logic [31:0]     off_full;
  logic [OFFW-1:0] off0;
  logic [LW-1:0]   lane0;
  logic [ROWW-1:0] row0, row1;
  logic [LANES-1:0] size_mask;
  logic            do_store, do_load;

  logic [BANK_AW-1:0] lane_addr  [LANES];
  logic [7:0]         lane_wdata [LANES];
  logic [7:0]         lane_rdata [LANES];
  logic [LANES-1:0]   lane_we;
  logic [63:0]        raw_data;

  rmb_regions #(
    .NUM_REGIONS(NUM_REGIONS)
  ) u_regions (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .address_i  (address_i),
    .match_o    (match)
  );

  assign accept = start && !busy;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (accept) state_d = ST_ACCESS;
      ST_ACCESS: state_d = ST_RESP;
      ST_RESP:   state_d = accept ? ST_ACCESS : ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    busy      = 1'b0;
    done_o    = 1'b0;
    in_access = 1'b0;
    unique case (state_q)
      ST_IDLE:   ;
      ST_ACCESS: begin
        busy      = 1'b1;
        in_access = 1'b1;
      end
      ST_RESP:   done_o = 1'b1;
      default:   ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Transaction capture; payload needs no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_e'(command_i);
      size_q  <= size_e'(access_size_i);
      addr_q  <= address_i;
      wdata_q <= write_data_i;
      match_q <= match;
    end
    if (in_access) begin
      lane0_q <= lane0;
    end
  end

  assign off_full = addr_q - match_q.base;
  assign off0     = off_full[OFFW-1:0];
  assign lane0    = off0[LW-1:0];
  assign row0     = off0[OFFW-1:LW];
  assign row1     = row0 + ROWW'(1);

  always_comb begin
    case (size_q)
      SIZE_BYTE:  size_mask = 8'h01;
      SIZE_WORD:  size_mask = 8'h03;
      SIZE_DWORD: size_mask = 8'h0F;
      default:    size_mask = 8'hFF;
    endcase
  end

  assign do_load  = in_access && match_q.hit && cmd_q == CMD_READ;
  assign do_store = in_access && match_q.hit &&
                    ((cmd_q == CMD_WRITE && !match_q.ro) || cmd_q == CMD_PRELOAD);

  // Lanes below the start lane take the next row (wrapping inside the region)
  always_comb begin
    logic [LW-1:0] k;
    for (int j = 0; j < LANES; j++) begin
      k             = LW'(j) - lane0;
      lane_addr[j]  = BANK_AW'({match_q.idx, (LW'(j) >= lane0) ? row0 : row1});
      lane_wdata[j] = wdata_q[8*k +: 8];
      lane_we[j]    = do_store && size_mask[k];
    end
  end

  for (genvar j = 0; j < LANES; j++) begin : g_lane
    rmb_ram #(
      .WIDTH(8),
      .DEPTH(BANK_DEPTH)
    ) u_bank (
      .clk_i  (clk_i),
      .we_i   (lane_we[j]),
      .re_i   (do_load),
      .addr_i (lane_addr[j]),
      .wdata_i(lane_wdata[j]),
      .rdata_o(lane_rdata[j])
    );
  end

  // Rotate lanes back into byte order
  always_comb begin
    logic [LW-1:0] lane;
    for (int k = 0; k < LANES; k++) begin
      lane               = lane0_q + LW'(k);
      raw_data[8*k +: 8] = lane_rdata[lane];
    end
  end

  always_comb begin
    read_data_o     = '0;
    fault_code_o    = FAULT_NONE;
    fault_address_o = '0;
    if (done_o && cmd_q != CMD_NOP) begin
      if (!match_q.hit) begin
        fault_code_o    = FAULT_ADDR;
        fault_address_o = addr_q;
      end else if (cmd_q == CMD_WRITE && match_q.ro) begin
        fault_code_o    = FAULT_RO;
        fault_address_o = addr_q;
      end else if (cmd_q == CMD_READ) begin
        case (size_q)
          SIZE_BYTE:  read_data_o = {{56{raw_data[7]}}, raw_data[7:0]};
          SIZE_WORD:  read_data_o = {{48{raw_data[15]}}, raw_data[15:0]};
          SIZE_DWORD: read_data_o = {{32{raw_data[31]}}, raw_data[31:0]};
          default:    read_data_o = raw_data;
        endcase
      end
    end
  end

  // Checks

  a_done_after_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ST_ACCESS))
    else $error("result strobe without a preceding store access");

  a_access_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> (!busy && done_o))
    else $error("store access did not complete in one cycle");

  a_no_write_on_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_access && (!match_q.hit || (cmd_q == CMD_WRITE && match_q.ro))) |-> lane_we == '0)
    else $error("store written by a faulting transaction");

  a_fault_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && fault_code_o != FAULT_NONE) |-> (read_data_o == '0))
    else $error("faulting transaction returned data");

endmodule
